// ===== sv/rcrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcrm_pkg
// shared types and constants for the call/reply match table
// ----------------------------------------------------------------------------
package rcrm_pkg;
  localparam int NUM_BUCKETS = 1024;
  localparam int WAYS = 4;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);
  localparam logic [7:0] MAX_AGE_RESET = 8'd30;
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [31:0] xid;
    logic [31:0] host;
    logic [15:0] port;
    logic [2:0]  version;
    logic [7:0]  proc;
    logic [31:0] prog;
    logic [31:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic        command;
    logic [31:0] xid;
    logic [31:0] host;
    logic [15:0] port;
    logic [2:0]  version;
    logic [7:0]  proc;
    logic [31:0] prog;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  found_version;
    logic [7:0]  found_proc;
    logic [31:0] found_prog;
    logic        evicted;
    logic [2:0]  culled_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_WR, ST_CRD, ST_CWR, ST_OUT
  } state_t;
endpackage

// ===== sv/rcrm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcrm_req_if / rcrm_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface rcrm_req_if import rcrm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcrm_rsp_if import rcrm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rpc_call_reply_match_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_call_reply_match_table_top
// hashed call table: insert, look up and remove, round robin aging cull
// ----------------------------------------------------------------------------
// channel | dir | contents
// in      | in  | command, key, call info, now
// out     | out | found info, evicted, culled count
// cfg     | in  | max_age write
// a lookup goes through accept, bucket read and write before output; an insert
// adds a cull bucket read and write; one memory port pair sets this order.
// after reset a clearing pass over all NUM_BUCKETS buckets runs before in_ready.
// a stalled result holds the block; the next request waits in ST_OUT.
module rpc_call_reply_match_table_top import rcrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rcrm_req_if.sink   in_ch,
  rcrm_rsp_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  entry_t          mem [NUM_BUCKETS][WAYS];
  logic [WAYS-1:0] vmem [NUM_BUCKETS];
  entry_t          rd_r [WAYS];
  logic [WAYS-1:0] rdv_r;

  state_t state_r, state_nxt;
  req_t   req_r;
  rsp_t   rsp_r, rsp_nxt;
  logic [7:0] max_age_r;
  logic [BW-1:0] cptr_r, cptr_nxt, clr_r;
  logic [BW-1:0] raddr, waddr, hbkt, bkt_r;
  logic we, vwe, in_rdy, out_vld;
  logic [WAYS-1:0] vw_data, wsel;
  entry_t wentry;

  assign hbkt = BW'((in_ch.data.xid % NUM_BUCKETS) + (in_ch.data.host % NUM_BUCKETS)
                + (in_ch.data.port % NUM_BUCKETS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == BW'(NUM_BUCKETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = (req_r.command == CMD_INSERT) ? ST_CRD : ST_OUT;
      ST_CRD:   state_nxt = ST_CWR;
      ST_CWR:   state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic [WW-1:0] hw, fw, ow;
  logic hit, has_free;
  logic [31:0] limit;
  logic [WAYS-1:0] kill;
  logic [CW-1:0] ccnt;

  always_comb begin
    hit = 1'b0; hw = '0; has_free = 1'b0; fw = '0; ow = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (rdv_r[k] && rd_r[k].xid == req_r.xid && rd_r[k].host == req_r.host &&
          rd_r[k].port == req_r.port) begin
        hit = 1'b1; hw = WW'(k);
      end
      if (!rdv_r[k]) begin
        has_free = 1'b1; fw = WW'(k);
      end
    end
    for (int k = 1; k < WAYS; k++)
      if (rd_r[k].tstamp < rd_r[ow].tstamp) ow = WW'(k);
    limit = req_r.now - {24'd0, max_age_r};
    ccnt = '0;
    for (int k = 0; k < WAYS; k++) begin
      kill[k] = rdv_r[k] && rd_r[k].tstamp < limit && req_r.now >= {24'd0, max_age_r};
      ccnt = ccnt + CW'(kill[k]);
    end
  end

  always_comb begin
    in_rdy = (state_r == ST_IDLE);
    out_vld = (state_r == ST_OUT);
    raddr = (state_r == ST_CRD) ? cptr_r : ((state_r == ST_IDLE) ? hbkt : bkt_r);
    we = 1'b0; vwe = 1'b0; waddr = bkt_r; wsel = '0; vw_data = rdv_r;
    wentry = '{req_r.xid, req_r.host, req_r.port, req_r.version, req_r.proc,
               req_r.prog, req_r.now};
    rsp_nxt = rsp_r;
    cptr_nxt = cptr_r;
    case (state_r)
      ST_CLEAR: begin
        vwe = 1'b1; waddr = clr_r; vw_data = '0;
      end
      ST_IDLE: rsp_nxt = '0;
      ST_WR: begin
        vwe = 1'b1;
        if (req_r.command == CMD_LOOKUP) begin
          if (hit) begin
            vw_data[hw] = 1'b0;
            rsp_nxt.found = 1'b1;
            rsp_nxt.found_version = rd_r[hw].version;
            rsp_nxt.found_proc = rd_r[hw].proc;
            rsp_nxt.found_prog = rd_r[hw].prog;
          end
        end else begin
          we = 1'b1;
          if (hit) wsel[hw] = 1'b1;
          else if (has_free) wsel[fw] = 1'b1;
          else begin
            wsel[ow] = 1'b1; rsp_nxt.evicted = 1'b1;
          end
          vw_data = rdv_r | wsel;
        end
      end
      ST_CWR: begin
        vwe = 1'b1; waddr = cptr_r; vw_data = rdv_r & ~kill;
        rsp_nxt.culled_count = 3'(ccnt);
        cptr_nxt = cptr_r + 1'b1;
      end
      default: ;
    endcase
  end

  // the cull read in ST_CRD sees the insert written in ST_WR (write first)
  always_ff @(posedge clk) begin
    if (vwe) vmem[waddr] <= vw_data;
    for (int k = 0; k < WAYS; k++)
      if (we && wsel[k]) mem[waddr][k] <= wentry;
    rdv_r <= vmem[raddr];
    for (int k = 0; k < WAYS; k++) rd_r[k] <= mem[raddr][k];
    if (in_rdy && in_ch.valid) begin
      req_r <= in_ch.data;
      bkt_r <= hbkt;
    end
    rsp_r <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      cptr_r <= '0;
      max_age_r <= MAX_AGE_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_r + 1'b1;
      cptr_r <= cptr_nxt;
      if (cfg_we) max_age_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = in_rdy;
  assign out_ch.valid = out_vld;
  assign out_ch.data = rsp_r;
endmodule

// ===== sv/rcrm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcrm_checker
// port level checks on the match table
// ----------------------------------------------------------------------------
module rcrm_checker import rcrm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && (out_data.evicted || out_data.culled_count != 0)))
    else $error("mixed result");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.found_prog == 0) else $error("miss data");
endmodule

bind rpc_call_reply_match_table_top rcrm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data)
);
